@@ hw/rtl/ilc_pkg.sv @@
// ----------------------------------------------------------------------------
// Integer literal converter package
// Character codes, state encodings and helper functions for the converter.
// ----------------------------------------------------------------------------
package ilc_pkg;

  // Character codes
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";
  localparam logic [7:0] CH_UNDER = "_";
  localparam logic [7:0] CH_SPACE = " ";
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_VT    = 8'h0B;
  localparam logic [7:0] CH_FF    = 8'h0C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_1     = "1";
  localparam logic [7:0] CH_2     = "2";
  localparam logic [7:0] CH_3     = "3";
  localparam logic [7:0] CH_4     = "4";
  localparam logic [7:0] CH_6     = "6";
  localparam logic [7:0] CH_8     = "8";
  localparam logic [7:0] CH_9     = "9";
  localparam logic [7:0] CH_UA    = "A";
  localparam logic [7:0] CH_UZ    = "Z";
  localparam logic [7:0] CH_LA    = "a";
  localparam logic [7:0] CH_LZ    = "z";
  localparam logic [7:0] CH_LB    = "b";
  localparam logic [7:0] CH_LI    = "i";
  localparam logic [7:0] CH_LO    = "o";
  localparam logic [7:0] CH_LX    = "x";

  // Digit value for a character that is no digit at all
  localparam logic [5:0] DIGIT_NONE = 6'd37;

  typedef enum logic [2:0] {
    PH_START  = 3'd0,  // expecting sign, space or digit
    PH_SIGNED = 3'd1,  // after sign or space
    PH_FIRST  = 3'd2,  // after first digit
    PH_BODY   = 3'd3,  // inside literal body
    PH_DONE   = 3'd4,  // literal ended, rest of token ignored
    PH_NAN    = 3'd5   // not a number
  } phase_e;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_NAN      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    W8  = 2'd0,
    W16 = 2'd1,
    W32 = 2'd2,
    W64 = 2'd3
  } width_e;

  // Snapshot of the token state taken on its last character
  typedef struct packed {
    logic [63:0] acc;
    radix_e      radix;
    logic        neg;
    logic        seen;
    status_e     err;
    logic [15:0] sfx;
    logic [1:0]  pos;
    logic        num;   // a literal was started (phase first, body or done)
  } fin_t;

  // Result word
  typedef struct packed {
    logic [63:0] value;
    width_e      width;
    status_e     status;
  } res_t;

  function automatic logic is_white_char(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_FF) || (c == CH_TAB) ||
           (c == CH_VT) || (c == CH_LF) || (c == CH_CR);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic logic is_lit(input logic [7:0] c);
    return ((c >= CH_UA) && (c <= CH_UZ)) || ((c >= CH_LA) && (c <= CH_LZ)) ||
           is_dec(c) || (c == CH_UNDER);
  endfunction

  function automatic logic [5:0] digit_of(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (is_dec(c)) begin
      v = c - CH_0;
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      v = c - CH_LA + 8'd10;
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      v = c - CH_UA + 8'd10;
    end else begin
      v = {2'b00, DIGIT_NONE};
    end
    return v[5:0];
  endfunction

  function automatic logic [5:0] base_of(input radix_e r);
    logic [5:0] b;
    case (r)
      RADIX_DEC: b = 6'd10;
      RADIX_HEX: b = 6'd16;
      RADIX_OCT: b = 6'd8;
      RADIX_BIN: b = 6'd2;
      default:   b = 6'd10;
    endcase
    return b;
  endfunction

  // Width from the held suffix (32 bits when there is none): bit 2 set means an invalid suffix
  function automatic logic [2:0] held_width(input logic [1:0] pos,
                                            input logic [15:0] sfx);
    logic [2:0] w;
    w = 3'b100;
    if (pos == 2'd0) begin
      w = {1'b0, W32};
    end else if (pos == 2'd2 && sfx[7:0] == CH_8) begin
      w = {1'b0, W8};
    end else if (pos == 2'd3) begin
      if (sfx[7:0] == CH_1 && sfx[15:8] == CH_6) begin
        w = {1'b0, W16};
      end else if (sfx[7:0] == CH_3 && sfx[15:8] == CH_2) begin
        w = {1'b0, W32};
      end else if (sfx[7:0] == CH_6 && sfx[15:8] == CH_4) begin
        w = {1'b0, W64};
      end
    end
    return w;
  endfunction

endpackage

@@ hw/rtl/integer_literal_converter.sv @@
// ----------------------------------------------------------------------------
// Integer literal converter
// Reads a literal token one character per word and returns its 64-bit
// sign-extended value, width and status on the token's last character.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                 | tuser                    | tlast
//  ---------+-----+-----------------------+--------------------------+-----------
//  s_axis   | in  | [7:0] ch              | -                        | last_char
//  m_axis   | out | [63:0] value (signed) | [1:0] width_code,        | -
//           |     |                       | [3:2] status             |
//
//  One character is taken every cycle while s_axis_tready is high; the
//  character loop (a 64-bit multiply-by-radix add with overflow check)
//  updates the token state in the cycle it is accepted. After the last
//  character the token passes the finish stage (range check, negate,
//  sign-extend), then the output register. s_axis_tready drops only
//  while both the finish stage and the output register hold words and
//  m_axis_tready is low. Reset (rst_ni low) clears the token state and
//  empties both stages.
module integer_literal_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tlast,   // last_char
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [63:0] value
  output logic [3:0]  m_axis_tuser    // [1:0] width_code, [3:2] status
);

  // Token state
  logic [63:0]          acc_q, acc_d;
  ilc_pkg::radix_e      radix_q, radix_d;
  ilc_pkg::phase_e      phase_q, phase_d;
  logic                 neg_q, neg_d;
  logic                 seen_q, seen_d;
  ilc_pkg::status_e     err_q, err_d;
  logic [15:0]          sfx_q, sfx_d;
  logic [1:0]           pos_q, pos_d;

  // Per-character next values
  logic [63:0]          n_acc;
  ilc_pkg::radix_e      n_radix;
  ilc_pkg::phase_e      n_phase;
  logic                 n_neg;
  logic                 n_seen;
  ilc_pkg::status_e     n_err;
  logic [15:0]          n_sfx;
  logic [1:0]           n_pos;

  logic [7:0]           ch;
  logic [5:0]           dig;
  logic [67:0]          prod;
  logic                 keep;
  logic                 in_acc;

  // Pipeline stages
  ilc_pkg::fin_t        fin_q, fin_d;
  logic                 fin_valid_q;
  ilc_pkg::res_t        res_q, res_d;
  logic                 res_valid_q;
  logic                 out_ready;
  logic                 fin_ready;

  assign ch        = s_axis_tdata;
  assign dig       = ilc_pkg::digit_of(ch);
  assign out_ready = !res_valid_q || m_axis_tready;
  assign fin_ready = !fin_valid_q || out_ready;
  assign s_axis_tready = fin_ready;
  assign in_acc    = s_axis_tvalid && fin_ready;

  // Accumulate: acc * radix + digit, carry-out in the top four bits
  always_comb begin
    case (radix_q)
      ilc_pkg::RADIX_DEC: prod = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
                                 + {64'd0, dig[3:0]};
      ilc_pkg::RADIX_HEX: prod = {acc_q, 4'b0000} + {64'd0, dig[3:0]};
      ilc_pkg::RADIX_OCT: prod = {1'b0, acc_q, 3'b000} + {64'd0, dig[3:0]};
      ilc_pkg::RADIX_BIN: prod = {3'b000, acc_q, 1'b0} + {64'd0, dig[3:0]};
      default:            prod = {4'd0, acc_q};
    endcase
  end

  // Apply one character to the token state
  always_comb begin
    n_acc   = acc_q;
    n_radix = radix_q;
    n_phase = phase_q;
    n_neg   = neg_q;
    n_seen  = seen_q;
    n_err   = err_q;
    n_sfx   = sfx_q;
    n_pos   = pos_q;
    keep    = 1'b0;
    case (phase_q)
      ilc_pkg::PH_START, ilc_pkg::PH_SIGNED: begin
        if (phase_q == ilc_pkg::PH_START &&
            (ch == ilc_pkg::CH_PLUS || ch == ilc_pkg::CH_MINUS)) begin
          n_neg   = (ch == ilc_pkg::CH_MINUS);
          n_phase = ilc_pkg::PH_SIGNED;
        end else if (ilc_pkg::is_white_char(ch)) begin
          n_phase = ilc_pkg::PH_SIGNED;
        end else if (ilc_pkg::is_dec(ch)) begin
          n_acc   = {56'd0, ch - ilc_pkg::CH_0};
          n_seen  = 1'b1;
          n_phase = ilc_pkg::PH_FIRST;
        end else begin
          n_phase = ilc_pkg::PH_NAN;
        end
      end
      ilc_pkg::PH_FIRST, ilc_pkg::PH_BODY: begin
        if (!ilc_pkg::is_lit(ch)) begin
          // literal ends here; the finish stage does the range work
          n_phase = ilc_pkg::PH_DONE;
        end else if (phase_q == ilc_pkg::PH_FIRST && acc_q == 64'd0 &&
                     (ch == ilc_pkg::CH_LX || ch == ilc_pkg::CH_LO ||
                      ch == ilc_pkg::CH_LB)) begin
          if (ch == ilc_pkg::CH_LX) begin
            n_radix = ilc_pkg::RADIX_HEX;
          end else if (ch == ilc_pkg::CH_LO) begin
            n_radix = ilc_pkg::RADIX_OCT;
          end else begin
            n_radix = ilc_pkg::RADIX_BIN;
          end
          n_seen  = 1'b0;
          n_phase = ilc_pkg::PH_BODY;
        end else begin
          n_phase = ilc_pkg::PH_BODY;
          if (pos_q != 2'd0) begin
            // extend or drop the held suffix
            if (pos_q == 2'd1) begin
              keep = (ch == ilc_pkg::CH_1) || (ch == ilc_pkg::CH_3) ||
                     (ch == ilc_pkg::CH_6) || (ch == ilc_pkg::CH_8);
            end else if (pos_q == 2'd2) begin
              keep = (sfx_q[7:0] == ilc_pkg::CH_1 && ch == ilc_pkg::CH_6) ||
                     (sfx_q[7:0] == ilc_pkg::CH_3 && ch == ilc_pkg::CH_2) ||
                     (sfx_q[7:0] == ilc_pkg::CH_6 && ch == ilc_pkg::CH_4);
            end
            if (keep) begin
              if (pos_q == 2'd1) begin
                n_sfx[7:0] = ch;
              end else begin
                n_sfx[15:8] = ch;
              end
              n_pos = pos_q + 2'd1;
            end else begin
              if (err_q == ilc_pkg::ST_OK) n_err = ilc_pkg::ST_INVALID;
              n_pos = 2'd0;
              n_sfx = 16'd0;
            end
          end else if (ch == ilc_pkg::CH_LI) begin
            n_pos = 2'd1;
            n_sfx = 16'd0;
          end else if (ch != ilc_pkg::CH_UNDER) begin
            if (dig >= ilc_pkg::base_of(radix_q)) begin
              if (err_q == ilc_pkg::ST_OK) n_err = ilc_pkg::ST_INVALID;
            end else begin
              n_seen = 1'b1;
              if (err_q == ilc_pkg::ST_OK) begin
                if (prod[67:64] != 4'd0) begin
                  n_err = ilc_pkg::ST_OVERFLOW;
                end else begin
                  n_acc = prod[63:0];
                end
              end
            end
          end
        end
      end
      default: begin
        // done or not a number: ignore the rest of the token
      end
    endcase
  end

  // Next token state: clear after the last character
  always_comb begin
    acc_d   = acc_q;
    radix_d = radix_q;
    phase_d = phase_q;
    neg_d   = neg_q;
    seen_d  = seen_q;
    err_d   = err_q;
    sfx_d   = sfx_q;
    pos_d   = pos_q;
    if (in_acc) begin
      if (s_axis_tlast) begin
        acc_d   = 64'd0;
        radix_d = ilc_pkg::RADIX_DEC;
        phase_d = ilc_pkg::PH_START;
        neg_d   = 1'b0;
        seen_d  = 1'b0;
        err_d   = ilc_pkg::ST_OK;
        sfx_d   = 16'd0;
        pos_d   = 2'd0;
      end else begin
        acc_d   = n_acc;
        radix_d = n_radix;
        phase_d = n_phase;
        neg_d   = n_neg;
        seen_d  = n_seen;
        err_d   = n_err;
        sfx_d   = n_sfx;
        pos_d   = n_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= 64'd0;
      radix_q <= ilc_pkg::RADIX_DEC;
      phase_q <= ilc_pkg::PH_START;
      neg_q   <= 1'b0;
      seen_q  <= 1'b0;
      err_q   <= ilc_pkg::ST_OK;
      sfx_q   <= 16'd0;
      pos_q   <= 2'd0;
    end else begin
      acc_q   <= acc_d;
      radix_q <= radix_d;
      phase_q <= phase_d;
      neg_q   <= neg_d;
      seen_q  <= seen_d;
      err_q   <= err_d;
      sfx_q   <= sfx_d;
      pos_q   <= pos_d;
    end
  end

  // Snapshot of the token on its last character
  always_comb begin
    fin_d.acc   = n_acc;
    fin_d.radix = n_radix;
    fin_d.neg   = n_neg;
    fin_d.seen  = n_seen;
    fin_d.err   = n_err;
    fin_d.sfx   = n_sfx;
    fin_d.pos   = n_pos;
    fin_d.num   = (n_phase == ilc_pkg::PH_FIRST) || (n_phase == ilc_pkg::PH_BODY) ||
                  (n_phase == ilc_pkg::PH_DONE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fin_valid_q <= 1'b0;
    end else if (fin_ready) begin
      fin_valid_q <= in_acc && s_axis_tlast;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast) begin
      fin_q <= fin_d;
    end
  end

  // Finish: suffix and digit checks, range check, negate or sign-extend
  logic [2:0]        hw;
  ilc_pkg::status_e  ferr;
  ilc_pkg::width_e   fw;
  logic [63:0]       mag;
  logic [63:0]       half;
  logic [63:0]       sext;
  logic              ge_half;
  logic              above_w;

  always_comb begin
    hw   = ilc_pkg::held_width(fin_q.pos, fin_q.sfx);
    mag  = fin_q.acc;
    fw   = ilc_pkg::width_e'(hw[1:0]);
    ferr = fin_q.err;
    if (ferr == ilc_pkg::ST_OK && hw[2]) ferr = ilc_pkg::ST_INVALID;
    if (ferr == ilc_pkg::ST_OK && !fin_q.seen) ferr = ilc_pkg::ST_INVALID;

    case (fw)
      ilc_pkg::W8: begin
        ge_half = |mag[63:7];
        above_w = |mag[63:8];
        half    = 64'h0000_0000_0000_0080;
        sext    = {{56{mag[7]}}, mag[7:0]};
      end
      ilc_pkg::W16: begin
        ge_half = |mag[63:15];
        above_w = |mag[63:16];
        half    = 64'h0000_0000_0000_8000;
        sext    = {{48{mag[15]}}, mag[15:0]};
      end
      ilc_pkg::W32: begin
        ge_half = |mag[63:31];
        above_w = |mag[63:32];
        half    = 64'h0000_0000_8000_0000;
        sext    = {{32{mag[31]}}, mag[31:0]};
      end
      default: begin
        ge_half = mag[63];
        above_w = 1'b0;
        half    = 64'h8000_0000_0000_0000;
        sext    = mag;
      end
    endcase

    res_d.value  = 64'd0;
    res_d.width  = ilc_pkg::W32;
    res_d.status = ilc_pkg::ST_OK;
    if (!fin_q.num) begin
      res_d.status = ilc_pkg::ST_NAN;
    end else if (ferr != ilc_pkg::ST_OK) begin
      res_d.status = ferr;
    end else if (fin_q.neg) begin
      if (ge_half && mag != half) begin
        res_d.status = ilc_pkg::ST_OVERFLOW;
      end else begin
        res_d.value = 64'd0 - mag;
        res_d.width = fw;
      end
    end else if (fin_q.radix == ilc_pkg::RADIX_DEC) begin
      if (ge_half) begin
        res_d.status = ilc_pkg::ST_OVERFLOW;
      end else begin
        res_d.value = mag;
        res_d.width = fw;
      end
    end else begin
      if (above_w) begin
        res_d.status = ilc_pkg::ST_OVERFLOW;
      end else begin
        res_d.value = sext;
        res_d.width = fw;
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (out_ready) begin
      res_valid_q <= fin_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready && fin_valid_q) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = res_q.value;
  assign m_axis_tuser  = {res_q.status, res_q.width};

endmodule
